// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted
`define BMMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge
`define BMMS_NEVER(lbl, cond, msg) \
    `BMMS_ASSERT(lbl, !(cond), msg)

`endif

// ===== sv/bmms_pkg.sv =====
// Shared types, constants and helpers of the button motor mode sequencer
package bmms_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int BTN_W       = 5;
    localparam int LANES       = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;

    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int LED_W       = 5;
    localparam int MODE_CODE_W = 3;
    localparam int NUM_MODES   = 6;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd200;
    localparam logic [CFG_W-1:0] ROTATION_RST = 16'd825;

    localparam int HALF_CYCLE_MS   = 3000;
    localparam int BLINK_PERIOD_MS = 1000;
    localparam int BLINK_ON_MS     = 500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 1'b0,
        REG_ROTATION = 1'b1
    } cfg_index_t;

    // Operating mode, one-hot: bit i is mode i
    typedef enum logic [NUM_MODES-1:0] {
        MODE_STOP    = 6'b000001,
        MODE_SWING   = 6'b000010,
        MODE_FWD     = 6'b000100,
        MODE_REV     = 6'b001000,
        MODE_ROT_FWD = 6'b010000,
        MODE_ROT_REV = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [BTN_W-1:0]  button_levels;
    } poll_t;

    typedef struct packed {
        logic                   motor_forward;
        logic                   motor_reverse;
        logic [LED_W-1:0]       led_pattern;
        logic [MODE_CODE_W-1:0] active_mode;
    } result_t;

    // What the merge stage hands to the output pipeline
    typedef struct packed {
        mode_t             mode;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    function automatic logic [MODE_CODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_CODE_W-1:0] code;
        unique case (m)
            MODE_STOP:    code = 3'd0;
            MODE_SWING:   code = 3'd1;
            MODE_FWD:     code = 3'd2;
            MODE_REV:     code = 3'd3;
            MODE_ROT_FWD: code = 3'd4;
            MODE_ROT_REV: code = 3'd5;
            default:      code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/button_motor_mode_sequencer_core.sv =====
// Top level of the button motor mode sequencer
// Each poll beat carries a millisecond timestamp and five active-low button
// levels; each poll gives exactly one result beat with the motor direction
// (both flags low means brake), the LED pattern and the mode after the poll.
// A poll is taken every cycle that poll_stall is low: the five button lanes
// check edge and debounce window side by side, the merge stage applies their
// presses in button order and updates the mode in the same cycle, so the
// next poll can follow at once. Stages s1 to s4 before the result register
// reduce elapsed time modulo 6000 and absolute time modulo 1000 for the swing
// direction and the blink of mode one. Stalls on the result side back up the
// pipeline stage by stage, so polls keep flowing into empty stages.
// debounce_ms (index 0, reset 200) and rotation_ms (index 1, reset 825) are
// written through cfg_we/cfg_index/cfg_data and should change only while idle.
`include "assert_macros.svh"
module button_motor_mode_sequencer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bmms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmms_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           poll_valid,
    output logic                           poll_stall,
    input  bmms_pkg::poll_t                poll,
    output logic                           result_valid,
    input  logic                           result_stall,
    output bmms_pkg::result_t              result
);

    logic [bmms_pkg::CFG_W-1:0] debounce_reg;
    logic [bmms_pkg::CFG_W-1:0] rotation_reg;
    logic [bmms_pkg::BTN_W-1:0] prev_levels_reg;
    logic [bmms_pkg::BTN_W-1:0] prev_levels_next;

    logic                       accept;
    logic [bmms_pkg::LANES-1:0] press;
    bmms_pkg::item_t            item;

    assign accept = poll_valid && !poll_stall;

    // all level bits are kept, even those of buttons with no lane
    assign prev_levels_next = accept ? poll.button_levels : prev_levels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= bmms_pkg::DEBOUNCE_RST;
            rotation_reg    <= bmms_pkg::ROTATION_RST;
            prev_levels_reg <= '1;
        end
        else
        begin
            prev_levels_reg <= prev_levels_next;
            if (cfg_we)
            begin
                unique case (bmms_pkg::cfg_index_t'(cfg_index))
                    bmms_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data;
                    bmms_pkg::REG_ROTATION: rotation_reg <= cfg_data;
                    default:                debounce_reg <= debounce_reg;
                endcase
            end
        end
    end

    // one lane per polled button
    for (genvar i = 0; i < bmms_pkg::LANES; i++)
    begin : g_lane
        bmms_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .accept      (accept),
            .now_ms      (poll.now_ms),
            .level       (poll.button_levels[i]),
            .prev_level  (prev_levels_reg[i]),
            .debounce_ms (debounce_reg),
            .press       (press[i])
        );
    end

    bmms_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .now_ms      (poll.now_ms),
        .press       (press),
        .rotation_ms (rotation_reg),
        .item        (item)
    );

    bmms_phase u_phase (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (poll_valid),
        .item         (item),
        .item_stall   (poll_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `BMMS_ASSERT(a_stall_cause, poll_stall |-> result_valid && result_stall, "poll stalled with output free")

endmodule

// ===== sv/bmms_lane.sv =====
// One button lane: edge detect, debounce window and last press time
module bmms_lane (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [bmms_pkg::TIME_W-1:0] now_ms,
    input  logic                       level,
    input  logic                       prev_level,
    input  logic [bmms_pkg::CFG_W-1:0] debounce_ms,
    output logic                       press
);

    logic [bmms_pkg::TIME_W-1:0] last_press_reg;
    logic [bmms_pkg::TIME_W-1:0] last_press_next;
    logic [bmms_pkg::TIME_W-1:0] since;

    // modular distance since the last accepted press
    assign since = now_ms - last_press_reg;
    assign press = prev_level && !level
                 && (since > {{(bmms_pkg::TIME_W-bmms_pkg::CFG_W){1'b0}}, debounce_ms});

    assign last_press_next = (accept && press) ? now_ms : last_press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_press_reg <= '0;
        end
        else
        begin
            last_press_reg <= last_press_next;
        end
    end

endmodule

// ===== sv/bmms_merge.sv =====
// Merges lane presses in button order into the mode and its start time
`include "assert_macros.svh"
module bmms_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [bmms_pkg::TIME_W-1:0] now_ms,
    input  logic [bmms_pkg::LANES-1:0]  press,
    input  logic [bmms_pkg::CFG_W-1:0]  rotation_ms,
    output bmms_pkg::item_t             item
);

    bmms_pkg::mode_t              mode_reg;
    bmms_pkg::mode_t              mode_next;
    logic [bmms_pkg::TIME_W-1:0]  mode_start_reg;
    logic [bmms_pkg::TIME_W-1:0]  mode_start_next;

    logic [bmms_pkg::NUM_MODES-1:0] mode_bits;
    logic                           started;
    logic [bmms_pkg::TIME_W-1:0]    elapsed;
    logic                           timed_out;

    always_comb
    begin
        mode_bits = mode_reg;
        started   = 1'b0;
        for (int i = 0; i < bmms_pkg::LANES; i++)
        begin
            if (press[i])
            begin
                if (mode_bits[i+1])
                begin
                    mode_bits = bmms_pkg::MODE_STOP;
                end
                else
                begin
                    mode_bits        = '0;
                    mode_bits[i+1]   = 1'b1;
                    started          = 1'b1;
                end
            end
        end
    end

    // a fresh start this poll means zero elapsed time
    assign elapsed = started ? '0 : (now_ms - mode_start_reg);
    assign timed_out = (mode_bits == bmms_pkg::MODE_ROT_FWD || mode_bits == bmms_pkg::MODE_ROT_REV)
                     && !(elapsed < {{(bmms_pkg::TIME_W-bmms_pkg::CFG_W){1'b0}}, rotation_ms});

    always_comb
    begin
        mode_next = timed_out ? bmms_pkg::MODE_STOP : bmms_pkg::mode_t'(mode_bits);
    end

    assign mode_start_next = started ? now_ms : mode_start_reg;

    assign item.mode    = mode_next;
    assign item.elapsed = elapsed;
    assign item.now_ms  = now_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= bmms_pkg::MODE_STOP;
            mode_start_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            mode_start_reg <= mode_start_next;
        end
    end

    `BMMS_ASSERT(a_mode_hold, accept && (press == '0) && !(mode_reg == bmms_pkg::MODE_ROT_FWD || mode_reg == bmms_pkg::MODE_ROT_REV) |=> mode_reg == $past(mode_reg), "mode changed with no press")
    `BMMS_ASSERT(a_start_hold, !accept |=> $stable(mode_start_reg), "mode start moved without a beat")

endmodule

// ===== sv/bmms_phase.sv =====
// Output pipeline: folds elapsed and absolute time, decodes motor and LEDs
`include "assert_macros.svh"
module bmms_phase (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  bmms_pkg::item_t   item,
    output logic              item_stall,
    output logic              result_valid,
    input  logic              result_stall,
    output bmms_pkg::result_t result
);

    localparam int STAGES = 5;

    // residues of byte weights: 2^24, 2^16 mod 6000 and mod 1000
    localparam logic [20:0] SW_B3 = 21'd1216;
    localparam logic [20:0] SW_B2 = 21'd5536;
    localparam logic [17:0] SW_H2 = 18'd5536;
    localparam logic [16:0] SW_H3 = 17'd5536;
    localparam logic [17:0] BL_B3 = 18'd216;
    localparam logic [17:0] BL_B2 = 18'd536;
    localparam logic [12:0] BL_K  = 13'd24;   // 1024 mod 1000

    // half-period crossings possible in the folded ranges
    localparam int SWING_STEPS = 27;
    localparam int BLINK_STEPS = 14;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] en;

    bmms_pkg::item_t   s1_item_reg;
    bmms_pkg::mode_t   s2_mode_reg;
    logic [20:0]       s2_sw_reg;
    logic [17:0]       s2_bl_reg;
    bmms_pkg::mode_t   s3_mode_reg;
    logic [17:0]       s3_sw_reg;
    logic [12:0]       s3_bl_reg;
    bmms_pkg::mode_t   s4_mode_reg;
    logic [16:0]       s4_sw_reg;
    logic              s4_blink_reg;
    bmms_pkg::result_t result_reg;

    logic [20:0]       s2_sw_next;
    logic [17:0]       s2_bl_next;
    logic [17:0]       s3_sw_next;
    logic [12:0]       s3_bl_next;
    logic [16:0]       s4_sw_next;
    logic              s4_blink_next;
    logic              fwd_half;
    bmms_pkg::result_t result_next;

    // stall chain: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || !result_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? item_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign item_stall   = !en[0];
    assign result_valid = valid_reg[STAGES-1];
    assign result       = result_reg;

    always_comb
    begin
        s2_sw_next = 21'(s1_item_reg.elapsed[31:24]) * SW_B3
                   + 21'(s1_item_reg.elapsed[23:16]) * SW_B2
                   + {5'b0, s1_item_reg.elapsed[15:8], 8'b0}
                   + 21'(s1_item_reg.elapsed[7:0]);
        s2_bl_next = 18'(s1_item_reg.now_ms[31:24]) * BL_B3
                   + 18'(s1_item_reg.now_ms[23:16]) * BL_B2
                   + {2'b0, s1_item_reg.now_ms[15:8], 8'b0}
                   + 18'(s1_item_reg.now_ms[7:0]);
        s3_sw_next = 18'(s2_sw_reg[20:16]) * SW_H2 + 18'(s2_sw_reg[15:0]);
        s3_bl_next = 13'(s2_bl_reg[17:10]) * BL_K + 13'(s2_bl_reg[9:0]);
        s4_sw_next = 17'(s3_sw_reg[17:16]) * SW_H3 + 17'(s3_sw_reg[15:0]);
    end

    // parity of the count of half periods passed: even means first half
    always_comb
    begin
        s4_blink_next = 1'b1;
        for (int k = 1; k <= BLINK_STEPS; k++)
        begin
            s4_blink_next = s4_blink_next ^ (s3_bl_reg >= 13'(k * bmms_pkg::BLINK_ON_MS));
        end
        fwd_half = 1'b1;
        for (int k = 1; k <= SWING_STEPS; k++)
        begin
            fwd_half = fwd_half ^ (s4_sw_reg >= 17'(k * bmms_pkg::HALF_CYCLE_MS));
        end
    end

    always_comb
    begin
        result_next.motor_forward = 1'b0;
        result_next.motor_reverse = 1'b0;
        result_next.led_pattern   = '0;
        result_next.active_mode   = bmms_pkg::mode_code(s4_mode_reg);
        unique case (s4_mode_reg)
            bmms_pkg::MODE_SWING:
            begin
                result_next.motor_forward  = fwd_half;
                result_next.motor_reverse  = !fwd_half;
                result_next.led_pattern[0] = s4_blink_reg;
            end
            bmms_pkg::MODE_FWD:
            begin
                result_next.motor_forward  = 1'b1;
                result_next.led_pattern[1] = 1'b1;
            end
            bmms_pkg::MODE_REV:
            begin
                result_next.motor_reverse  = 1'b1;
                result_next.led_pattern[2] = 1'b1;
            end
            bmms_pkg::MODE_ROT_FWD:
            begin
                result_next.motor_forward  = 1'b1;
                result_next.led_pattern[3] = 1'b1;
            end
            bmms_pkg::MODE_ROT_REV:
            begin
                result_next.motor_reverse  = 1'b1;
                result_next.led_pattern[4] = 1'b1;
            end
            default:
            begin
                result_next.motor_forward = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_item_reg <= item;
        end
        if (en[1])
        begin
            s2_mode_reg <= s1_item_reg.mode;
            s2_sw_reg   <= s2_sw_next;
            s2_bl_reg   <= s2_bl_next;
        end
        if (en[2])
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_sw_reg   <= s3_sw_next;
            s3_bl_reg   <= s3_bl_next;
        end
        if (en[3])
        begin
            s4_mode_reg  <= s3_mode_reg;
            s4_sw_reg    <= s4_sw_next;
            s4_blink_reg <= s4_blink_next;
        end
        if (en[4])
        begin
            result_reg <= result_next;
        end
    end

    `BMMS_NEVER(a_dir_clash, result_valid && result.motor_forward && result.motor_reverse, "forward and reverse both driven")
    `BMMS_ASSERT(a_stop_dark, result_valid && (result.active_mode == bmms_pkg::mode_code(bmms_pkg::MODE_STOP)) |-> (result.led_pattern == '0) && !result.motor_forward && !result.motor_reverse, "stopped beat not dark")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the button motor mode sequencer core
module testbench;

    // Mode as it shows up in the result's active_mode field
    typedef enum logic [2:0] {
        RUN_STOP    = 3'd0,
        RUN_SWING   = 3'd1,
        RUN_FWD     = 3'd2,
        RUN_REV     = 3'd3,
        RUN_ROT_FWD = 3'd4,
        RUN_ROT_REV = 3'd5
    } run_mode_t;

    localparam int unsigned SWING_PERIOD_MS  = 2 * bmms_pkg::HALF_CYCLE_MS;
    localparam int          PHASE_POLLS      = 115;
    localparam int          NUM_PHASES       = 6;
    localparam int          DRAIN_CYCLES     = 10;
    localparam int          LONG_HOLD_CYCLES = 48;

    // Tracks the sequencer's state from accepted polls and keeps the
    // expected result beats in order of arrival.
    class sequencer_scoreboard;
        bmms_pkg::result_t          expected_results[$];
        logic [bmms_pkg::CFG_W-1:0] debounce_ms;
        logic [bmms_pkg::CFG_W-1:0] rotation_ms;
        logic [bmms_pkg::BTN_W-1:0] prev_levels;
        logic [31:0]                last_press[bmms_pkg::LANES];
        run_mode_t                  mode;
        logic [31:0]                mode_start;
        int                         mismatches;

        function new();
            debounce_ms = bmms_pkg::DEBOUNCE_RST;
            rotation_ms = bmms_pkg::ROTATION_RST;
            prev_levels = '1;
            foreach (last_press[i]) last_press[i] = '0;
            mode        = RUN_STOP;
            mode_start  = '0;
            mismatches  = 0;
        endfunction

        function void set_config(bmms_pkg::cfg_index_t idx, logic [bmms_pkg::CFG_W-1:0] data);
            case (idx)
                bmms_pkg::REG_DEBOUNCE: debounce_ms = data;
                bmms_pkg::REG_ROTATION: rotation_ms = data;
                default: ;
            endcase
        endfunction

        // Apply one poll and queue the result it must produce
        function void note_poll(bmms_pkg::poll_t p);
            bmms_pkg::result_t r;
            logic [31:0]       since;
            logic [31:0]       elapsed;
            r = '0;
            // buttons in index order; a later press in the same poll wins
            for (int i = 0; i < bmms_pkg::LANES; i++) begin
                since = p.now_ms - last_press[i];
                if (!p.button_levels[i] && prev_levels[i] && since > debounce_ms) begin
                    if (int'(mode) == i + 1) begin
                        mode = RUN_STOP;
                    end
                    else begin
                        mode       = run_mode_t'(i + 1);
                        mode_start = p.now_ms;
                    end
                    last_press[i] = p.now_ms;
                end
            end
            prev_levels = p.button_levels;

            elapsed = p.now_ms - mode_start;
            case (mode)
                RUN_SWING: begin
                    if (elapsed % SWING_PERIOD_MS < bmms_pkg::HALF_CYCLE_MS)
                        r.motor_forward = 1'b1;
                    else
                        r.motor_reverse = 1'b1;
                    if (p.now_ms % bmms_pkg::BLINK_PERIOD_MS < bmms_pkg::BLINK_ON_MS)
                        r.led_pattern = 5'b00001;
                end
                RUN_FWD: begin
                    r.motor_forward = 1'b1;
                    r.led_pattern   = 5'b00010;
                end
                RUN_REV: begin
                    r.motor_reverse = 1'b1;
                    r.led_pattern   = 5'b00100;
                end
                RUN_ROT_FWD, RUN_ROT_REV: begin
                    if (elapsed < rotation_ms) begin
                        if (mode == RUN_ROT_FWD) begin
                            r.motor_forward = 1'b1;
                            r.led_pattern   = 5'b01000;
                        end
                        else begin
                            r.motor_reverse = 1'b1;
                            r.led_pattern   = 5'b10000;
                        end
                    end
                    else begin
                        mode = RUN_STOP;  // timed out: brake in this same poll
                    end
                end
                default: ;
            endcase
            r.active_mode = mode;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            mismatches++;
        endtask

        task check_result(bmms_pkg::result_t got);
            bmms_pkg::result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result beat with no poll outstanding");
            end
            else begin
                want = expected_results.pop_front();
                if (got.motor_forward !== want.motor_forward)
                    report_mismatch($sformatf("motor_forward got %b want %b",
                                              got.motor_forward, want.motor_forward));
                if (got.motor_reverse !== want.motor_reverse)
                    report_mismatch($sformatf("motor_reverse got %b want %b",
                                              got.motor_reverse, want.motor_reverse));
                if (got.led_pattern !== want.led_pattern)
                    report_mismatch($sformatf("led_pattern got %b want %b",
                                              got.led_pattern, want.led_pattern));
                if (got.active_mode !== want.active_mode)
                    report_mismatch($sformatf("active_mode got %0d want %0d",
                                              got.active_mode, want.active_mode));
            end
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bmms_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bmms_pkg::CFG_W-1:0]     cfg_data;
    logic                           poll_valid;
    logic                           poll_stall;
    bmms_pkg::poll_t                poll;
    logic                           result_valid;
    logic                           result_stall;
    bmms_pkg::result_t              result;

    sequencer_scoreboard board;

    // Idle rates in percent; the main sequence moves through the regimes
    int send_idle_pct;
    int recv_idle_pct;
    // Set by the main sequence, taken and cleared by the receiver process
    bit long_hold_req;

    button_motor_mode_sequencer_core dut (.*);

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // Receiver: random stall each cycle, plus the occasional long hold-off
    // that lets the pipeline fill until the block stalls its poll input.
    initial begin
        int hold_left;
        hold_left    = 0;
        result_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                hold_left     = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else begin
                result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Result side: a beat moves on a rising edge with valid high and stall low
    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);
    end

    // Offer one poll beat, with random idle cycles ahead of it. Starts and
    // returns at a falling edge; valid is left high so back-to-back beats
    // never see a drop.
    task automatic send_poll(input logic [31:0] stamp, input logic [4:0] levels);
        while ($urandom_range(99) < send_idle_pct) begin
            poll_valid <= 1'b0;
            @(negedge clk);
        end
        poll_valid <= 1'b1;
        poll       <= '{now_ms: stamp, button_levels: levels};
        @(posedge clk);
        while (poll_stall) @(posedge clk);
        board.note_poll(poll);
        @(negedge clk);
    endtask

    // Reprogram both registers once the block has drained
    task automatic write_settings(input logic [15:0] debounce, input logic [15:0] rotation);
        poll_valid <= 1'b0;
        while (board.expected_results.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bmms_pkg::REG_DEBOUNCE;
        cfg_data  <= debounce;
        @(negedge clk);
        cfg_index <= bmms_pkg::REG_ROTATION;
        cfg_data  <= rotation;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_config(bmms_pkg::REG_DEBOUNCE, debounce);
        board.set_config(bmms_pkg::REG_ROTATION, rotation);
    endtask

    initial begin
        int          pick;
        logic [31:0] stamp_ms;
        logic [4:0]  held;
        logic [4:0]  levels;

        board         = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        poll_valid    = 1'b0;
        poll          = '0;
        long_hold_req = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 65;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed walk with reset settings (debounce 200, rotation 825)
        send_poll(32'd0,    5'b11111);  // stopped at time zero
        send_poll(32'd100,  5'b11110);  // press too soon after time zero: rejected
        send_poll(32'd150,  5'b11111);
        send_poll(32'd1000, 5'b11110);  // swing starts, blink on
        send_poll(32'd4200, 5'b11110);  // held, past half cycle: reverse
        send_poll(32'd4700, 5'b11111);  // blink off
        send_poll(32'd4800, 5'b11110);  // same button again: stop
        send_poll(32'd4900, 5'b11111);
        send_poll(32'd5000, 5'b11101);  // forward
        send_poll(32'd5100, 5'b11111);
        send_poll(32'd5400, 5'b11011);  // reverse, switch without stopping
        send_poll(32'd5500, 5'b11111);
        send_poll(32'd5600, 5'b10111);  // one-rotation forward
        send_poll(32'd6000, 5'b11111);  // still turning
        send_poll(32'd6425, 5'b11111);  // rotation time reached: stop
        send_poll(32'd6500, 5'b01111);  // one-rotation reverse
        send_poll(32'd6510, 5'b01111);  // held, no edge
        send_poll(32'd6520, 5'b11111);
        send_poll(32'd6530, 5'b01111);  // bounce inside debounce window
        send_poll(32'd7000, 5'b11111);
        send_poll(32'd7000, 5'b00000);  // all five at once: last button wins
        send_poll(32'hFFFF_FF00, 5'b11111);
        send_poll(32'hFFFF_FFFF, 5'b11110);  // swing starts at top of range
        send_poll(32'h0000_0100, 5'b11111);  // timestamp wrapped
        send_poll(32'h0000_0200, 5'b11110);  // debounce across the wrap: stop

        // Random phases: well-formed press/release traffic over a moving
        // time base, with jumps, repeats and some raw level noise.
        stamp_ms = 32'h0000_0300;
        held     = '1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 28;
                recv_idle_pct = 65;
            end
            else if (phase < 4) begin
                send_idle_pct = 65;
                recv_idle_pct = 28;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                1: write_settings(16'd0, 16'd0);
                2: write_settings(16'hFFFF, 16'hFFFF);
                3: write_settings(16'd50, 16'd3000);
                4: write_settings(16'($urandom_range(1000)), 16'($urandom_range(8000)));
                5: write_settings(bmms_pkg::DEBOUNCE_RST, bmms_pkg::ROTATION_RST);
                default: ;
            endcase
            if (phase == 1 || phase == 4)
                long_hold_req = 1'b1;

            repeat (PHASE_POLLS) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    stamp_ms += $urandom_range(300);
                else if (pick < 85)
                    stamp_ms += $urandom_range(4000, 300);
                else if (pick < 93)
                    stamp_ms += $urandom_range(80000, 4000);
                else if (pick < 97)
                    stamp_ms = $urandom();
                // otherwise the same timestamp again

                pick = $urandom_range(99);
                if (pick < 30)
                    held[$urandom_range(4)] = 1'b0;
                else if (pick < 70)
                    held = '1;
                levels = ($urandom_range(99) < 8) ? 5'($urandom()) : held;
                send_poll(stamp_ms, levels);
            end
        end

        poll_valid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
